// File: src/cpuls_pkg.sv
// cpuls_pkg: shared types, constants and state encodings of the cpu load smoother
`default_nettype none

package cpuls_pkg;

    localparam int CHANNELS     = 4;
    localparam int CH_BITS      = $clog2(CHANNELS);
    localparam int COUNTER_BITS = 32;
    localparam int SUM_BITS     = COUNTER_BITS + CH_BITS;
    localparam int SHARE_BITS   = 23;
    localparam int PCT_BITS     = 15;
    localparam int COEFF_BITS   = 16;
    localparam int WEIGHT_BITS  = COEFF_BITS + 1;
    localparam int ACC_BITS     = WEIGHT_BITS + SHARE_BITS;
    localparam int FRAC_BITS    = 16;
    localparam int OUT_SHIFT    = 8;
    localparam int D25_BITS     = COUNTER_BITS + 5;
    localparam int LOW_PAD      = 18;
    localparam int DIV_STEPS    = SHARE_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS + 1);

    typedef logic [COUNTER_BITS-1:0] ticks_t;
    typedef logic [SUM_BITS-1:0]     sum_t;
    typedef logic [SHARE_BITS-1:0]   share_t;
    typedef logic [PCT_BITS-1:0]     pct_t;
    typedef logic [COEFF_BITS-1:0]   coeff_t;
    typedef logic [CH_BITS-1:0]      chan_t;

    localparam share_t FULL_SCALE  = SHARE_BITS'(6553600);
    localparam coeff_t COEFF_RESET = COEFF_BITS'(53620);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DIV_WAIT,
        ST_EMA,
        ST_EMA_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        EMA_IDLE,
        EMA_OLD,
        EMA_NEW,
        EMA_ROUND
    } ema_phase_t;

    typedef struct packed {
        logic   start;
        ticks_t delta;
        sum_t   total;
    } div_req_t;

    typedef struct packed {
        logic   start;
        coeff_t coeff;
        share_t old_share;
        share_t sample_share;
    } ema_req_t;

    typedef struct packed {
        logic   done;
        share_t value;
    } unit_rsp_t;

endpackage

`default_nettype wire

// File: src/cpuls_if.sv
// cpuls_if: valid/ready channel interfaces for tick samples and smoothed results
`default_nettype none

interface cpuls_sample_if;
    logic                  valid;
    logic                  ready;
    logic [cpuls_pkg::COUNTER_BITS-1:0] user_ticks;
    logic [cpuls_pkg::COUNTER_BITS-1:0] nice_ticks;
    logic [cpuls_pkg::COUNTER_BITS-1:0] system_ticks;
    logic [cpuls_pkg::COUNTER_BITS-1:0] idle_ticks;

    modport source (
        output valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
        input  ready
    );
    modport sink (
        input  valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
        output ready
    );
endinterface

interface cpuls_result_if;
    logic                          valid;
    logic                          ready;
    logic [cpuls_pkg::PCT_BITS-1:0] user_pct;
    logic [cpuls_pkg::PCT_BITS-1:0] nice_pct;
    logic [cpuls_pkg::PCT_BITS-1:0] system_pct;
    logic [cpuls_pkg::PCT_BITS-1:0] idle_pct;
    logic                          primed;

    modport source (
        output valid, user_pct, nice_pct, system_pct, idle_pct, primed,
        input  ready
    );
    modport sink (
        input  valid, user_pct, nice_pct, system_pct, idle_pct, primed,
        output ready
    );
endinterface

`default_nettype wire

// File: src/cpuls_div.sv
// cpuls_div: bit-serial restoring divider giving round(delta * 6553600 / total)
`default_nettype none

module cpuls_div (
    input  logic                clk,
    input  logic                rst_n,
    input  cpuls_pkg::div_req_t req,
    output cpuls_pkg::unit_rsp_t rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [cpuls_pkg::STEP_BITS-1:0]  count_reg;
    cpuls_pkg::sum_t                  rem_reg;
    cpuls_pkg::sum_t                  total_reg;
    cpuls_pkg::share_t                low_reg;
    cpuls_pkg::share_t                quot_reg;
    cpuls_pkg::share_t                result_reg;

    logic [cpuls_pkg::D25_BITS-1:0]   d_ext;
    logic [cpuls_pkg::D25_BITS-1:0]   d25;
    logic [cpuls_pkg::SUM_BITS:0]     trial;
    logic [cpuls_pkg::SUM_BITS:0]     divisor_ext;
    logic [cpuls_pkg::SUM_BITS:0]     diff;
    logic                             take;
    cpuls_pkg::sum_t                  rem_next;
    logic                             half_up;
    logic [cpuls_pkg::SHARE_BITS:0]   rounded;
    cpuls_pkg::share_t                clamped;

    // numerator is delta * 25 * 2^18; its top bits start the remainder below total
    always_comb
    begin
        d_ext = cpuls_pkg::D25_BITS'(req.delta);
        d25   = (d_ext << 4) + (d_ext << 3) + d_ext;
    end

    always_comb
    begin
        divisor_ext = {1'b0, total_reg};
        trial       = {rem_reg, low_reg[cpuls_pkg::SHARE_BITS-1]};
        take        = (trial >= divisor_ext);
        diff        = trial - divisor_ext;
        rem_next    = take ? diff[cpuls_pkg::SUM_BITS-1:0]
                           : trial[cpuls_pkg::SUM_BITS-1:0];
        // halves round up: 2r >= total
        half_up     = ({rem_reg, 1'b0} >= divisor_ext);
        rounded     = {1'b0, quot_reg} + (cpuls_pkg::SHARE_BITS + 1)'(half_up);
        if (rounded > {1'b0, cpuls_pkg::FULL_SCALE})
        begin
            clamped = cpuls_pkg::FULL_SCALE;
        end
        else
        begin
            clamped = rounded[cpuls_pkg::SHARE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= cpuls_pkg::STEP_BITS'(cpuls_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            total_reg <= req.total;
            rem_reg   <= cpuls_pkg::SUM_BITS'(d25[cpuls_pkg::D25_BITS-1:5]);
            low_reg   <= {d25[4:0], {cpuls_pkg::LOW_PAD{1'b0}}};
            quot_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (count_reg != '0)
            begin
                rem_reg  <= rem_next;
                low_reg  <= {low_reg[cpuls_pkg::SHARE_BITS-2:0], 1'b0};
                quot_reg <= {quot_reg[cpuls_pkg::SHARE_BITS-2:0], take};
            end
            else
            begin
                result_reg <= clamped;
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = result_reg;

endmodule

`default_nettype wire

// File: src/cpuls_ema.sv
// cpuls_ema: first-order smoother step on one shared multiplier, in old, new and round phases a channel
`default_nettype none

module cpuls_ema (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpuls_pkg::ema_req_t  req,
    output cpuls_pkg::unit_rsp_t rsp
);

    cpuls_pkg::ema_phase_t              phase_reg;
    cpuls_pkg::ema_phase_t              phase_next;
    logic                               done_reg;
    cpuls_pkg::coeff_t                  coeff_reg;
    cpuls_pkg::share_t                  old_reg;
    cpuls_pkg::share_t                  sample_reg;
    logic [cpuls_pkg::ACC_BITS-1:0]     acc_reg;
    cpuls_pkg::share_t                  result_reg;

    logic [cpuls_pkg::WEIGHT_BITS-1:0]  weight;
    logic [cpuls_pkg::WEIGHT_BITS-1:0]  op_a;
    cpuls_pkg::share_t                  op_b;
    logic [cpuls_pkg::ACC_BITS-1:0]     product;
    logic [cpuls_pkg::ACC_BITS-cpuls_pkg::FRAC_BITS-1:0] scaled;
    cpuls_pkg::share_t                  clamped;

    // new-sample weight is 1.0 - c1 in Q1.16
    assign weight = {1'b1, {cpuls_pkg::COEFF_BITS{1'b0}}}
                  - {1'b0, coeff_reg};

    always_comb
    begin
        if (phase_reg == cpuls_pkg::EMA_NEW)
        begin
            op_a = weight;
            op_b = sample_reg;
        end
        else
        begin
            op_a = {1'b0, coeff_reg};
            op_b = old_reg;
        end
        product = cpuls_pkg::ACC_BITS'(op_a) * cpuls_pkg::ACC_BITS'(op_b);
        scaled  = acc_reg[cpuls_pkg::ACC_BITS-1:cpuls_pkg::FRAC_BITS];
        if (scaled > (cpuls_pkg::ACC_BITS - cpuls_pkg::FRAC_BITS)'(cpuls_pkg::FULL_SCALE))
        begin
            clamped = cpuls_pkg::FULL_SCALE;
        end
        else
        begin
            clamped = scaled[cpuls_pkg::SHARE_BITS-1:0];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            cpuls_pkg::EMA_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = cpuls_pkg::EMA_OLD;
                end
            end
            cpuls_pkg::EMA_OLD:   phase_next = cpuls_pkg::EMA_NEW;
            cpuls_pkg::EMA_NEW:   phase_next = cpuls_pkg::EMA_ROUND;
            cpuls_pkg::EMA_ROUND: phase_next = cpuls_pkg::EMA_IDLE;
            default:              phase_next = cpuls_pkg::EMA_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cpuls_pkg::EMA_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == cpuls_pkg::EMA_ROUND);
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == cpuls_pkg::EMA_IDLE && req.start)
        begin
            coeff_reg  <= req.coeff;
            old_reg    <= req.old_share;
            sample_reg <= req.sample_share;
        end
        if (phase_reg == cpuls_pkg::EMA_OLD)
        begin
            acc_reg <= product + cpuls_pkg::ACC_BITS'(32768);
        end
        else if (phase_reg == cpuls_pkg::EMA_NEW)
        begin
            acc_reg <= acc_reg + product;
        end
        if (phase_reg == cpuls_pkg::EMA_ROUND)
        begin
            result_reg <= clamped;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = result_reg;

endmodule

`default_nettype wire

// File: src/cpu_load_percent_smoother.sv
// cpu_load_percent_smoother: top level with sequencer, counter state and result register
`default_nettype none

// Takes four cumulative tick counters (user, nice, system, idle) per beat, forms wrapping
// differences against the previous beat, turns each into a share of their sum in Q7.16
// and smooths it with s' = c1*s + (1-c1)*p, c1 being the retention_coeff register
// (Q0.16, reset 53620). Results come out rounded to Q7.8 percent. The first beat after
// reset only stores the counters and returns zeros with primed low. The channels are
// handled one after another: each runs through a 23-step bit-serial divider and a
// multiply-accumulate in old, new and round steps on one shared multiplier. A priming
// beat goes straight to the result register, and a beat with all differences zero
// skips the divider. The input is ready only between beats, in the cycle after the
// previous result is loaded; a new beat may be taken while the previous result still
// waits in the output register. Write retention_coeff only while no beat is in flight;
// it applies from the next beat on.
module cpu_load_percent_smoother (
    input  logic                        clk,
    input  logic                        rst_n,
    cpuls_sample_if.sink                sample,
    cpuls_result_if.source              result,
    input  logic                        wr_en,
    input  logic [cpuls_pkg::COEFF_BITS-1:0] wr_data
);

    cpuls_pkg::ctrl_state_t state_reg;
    cpuls_pkg::ctrl_state_t state_next;

    cpuls_pkg::coeff_t  coeff_reg;
    logic               has_prev_reg;
    cpuls_pkg::chan_t   ch_reg;
    cpuls_pkg::ticks_t  prev_reg   [cpuls_pkg::CHANNELS];
    cpuls_pkg::ticks_t  delta_reg  [cpuls_pkg::CHANNELS];
    cpuls_pkg::share_t  smooth_reg [cpuls_pkg::CHANNELS];
    cpuls_pkg::pct_t    stage_reg  [cpuls_pkg::CHANNELS];
    logic               stage_primed_reg;
    cpuls_pkg::sum_t    sum_reg;
    cpuls_pkg::sum_t    sum_next;
    cpuls_pkg::share_t  share_reg;
    logic               out_valid_reg;
    cpuls_pkg::pct_t    out_pct_reg [cpuls_pkg::CHANNELS];
    logic               out_primed_reg;

    cpuls_pkg::ticks_t  in_ticks [cpuls_pkg::CHANNELS];
    logic               accept;
    logic               load_out;
    logic               last_ch;
    logic [cpuls_pkg::SHARE_BITS:0] rounded;
    cpuls_pkg::pct_t    new_pct;

    cpuls_pkg::div_req_t  div_req;
    cpuls_pkg::unit_rsp_t div_rsp;
    cpuls_pkg::ema_req_t  ema_req;
    cpuls_pkg::unit_rsp_t ema_rsp;

    assign in_ticks[0] = sample.user_ticks;
    assign in_ticks[1] = sample.nice_ticks;
    assign in_ticks[2] = sample.system_ticks;
    assign in_ticks[3] = sample.idle_ticks;

    assign sample.ready = (state_reg == cpuls_pkg::ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign load_out     = (state_reg == cpuls_pkg::ST_FINISH)
                       && (!out_valid_reg || result.ready);
    assign last_ch      = (ch_reg == cpuls_pkg::CH_BITS'(cpuls_pkg::CHANNELS - 1));

    assign div_req.start = (state_reg == cpuls_pkg::ST_DIV) && (sum_reg != '0);
    assign div_req.delta = delta_reg[ch_reg];
    assign div_req.total = sum_reg;

    assign ema_req.start        = (state_reg == cpuls_pkg::ST_EMA);
    assign ema_req.coeff        = coeff_reg;
    assign ema_req.old_share    = smooth_reg[ch_reg];
    assign ema_req.sample_share = share_reg;

    cpuls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    cpuls_ema u_ema (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ema_req),
        .rsp   (ema_rsp)
    );

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < cpuls_pkg::CHANNELS; i++)
        begin
            sum_next = sum_next + cpuls_pkg::SUM_BITS'(delta_reg[i]);
        end
        // Q7.16 to Q7.8 with halves rounded up
        rounded = {1'b0, ema_rsp.value} + (cpuls_pkg::SHARE_BITS + 1)'(128);
        new_pct = rounded[cpuls_pkg::OUT_SHIFT +: cpuls_pkg::PCT_BITS];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpuls_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = has_prev_reg ? cpuls_pkg::ST_SUM : cpuls_pkg::ST_FINISH;
                end
            end
            cpuls_pkg::ST_SUM:
            begin
                state_next = cpuls_pkg::ST_DIV;
            end
            cpuls_pkg::ST_DIV:
            begin
                // zero sum skips the divider, share is zero
                state_next = (sum_reg != '0) ? cpuls_pkg::ST_DIV_WAIT : cpuls_pkg::ST_EMA;
            end
            cpuls_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = cpuls_pkg::ST_EMA;
                end
            end
            cpuls_pkg::ST_EMA:
            begin
                state_next = cpuls_pkg::ST_EMA_WAIT;
            end
            cpuls_pkg::ST_EMA_WAIT:
            begin
                if (ema_rsp.done)
                begin
                    state_next = last_ch ? cpuls_pkg::ST_FINISH : cpuls_pkg::ST_DIV;
                end
            end
            cpuls_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = cpuls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpuls_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpuls_pkg::ST_IDLE;
            coeff_reg     <= cpuls_pkg::COEFF_RESET;
            has_prev_reg  <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < cpuls_pkg::CHANNELS; i++)
            begin
                prev_reg[i]   <= '0;
                smooth_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                coeff_reg <= wr_data;
            end
            if (accept)
            begin
                has_prev_reg <= 1'b1;
                ch_reg       <= '0;
                for (int i = 0; i < cpuls_pkg::CHANNELS; i++)
                begin
                    prev_reg[i] <= in_ticks[i];
                end
            end
            if (state_reg == cpuls_pkg::ST_EMA_WAIT && ema_rsp.done)
            begin
                smooth_reg[ch_reg] <= ema_rsp.value;
                ch_reg             <= ch_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_primed_reg <= has_prev_reg;
            for (int i = 0; i < cpuls_pkg::CHANNELS; i++)
            begin
                delta_reg[i] <= in_ticks[i] - prev_reg[i];
                stage_reg[i] <= '0;
            end
        end
        if (state_reg == cpuls_pkg::ST_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == cpuls_pkg::ST_DIV && sum_reg == '0)
        begin
            share_reg <= '0;
        end
        else if (state_reg == cpuls_pkg::ST_DIV_WAIT && div_rsp.done)
        begin
            share_reg <= div_rsp.value;
        end
        if (state_reg == cpuls_pkg::ST_EMA_WAIT && ema_rsp.done)
        begin
            stage_reg[ch_reg] <= new_pct;
        end
        if (load_out)
        begin
            out_primed_reg <= stage_primed_reg;
            for (int i = 0; i < cpuls_pkg::CHANNELS; i++)
            begin
                out_pct_reg[i] <= stage_reg[i];
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.user_pct   = out_pct_reg[0];
    assign result.nice_pct   = out_pct_reg[1];
    assign result.system_pct = out_pct_reg[2];
    assign result.idle_pct   = out_pct_reg[3];
    assign result.primed     = out_primed_reg;

    // divider answers only while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == cpuls_pkg::ST_DIV_WAIT)
        else $error("divider done outside its wait state");

    // a new result beat is only loaded from the finish state
    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == cpuls_pkg::ST_FINISH))
        else $error("result beat loaded outside finish state");

    // priming beat carries all-zero shares
    a_priming_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.primed) |->
            (result.user_pct == '0 && result.nice_pct == '0
             && result.system_pct == '0 && result.idle_pct == '0))
        else $error("priming beat with nonzero shares");

    // smoothed shares never pass 100 percent
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            (result.user_pct <= cpuls_pkg::PCT_BITS'(25600)
             && result.nice_pct <= cpuls_pkg::PCT_BITS'(25600)
             && result.system_pct <= cpuls_pkg::PCT_BITS'(25600)
             && result.idle_pct <= cpuls_pkg::PCT_BITS'(25600)))
        else $error("share above full scale");

endmodule

`default_nettype wire
